// ===== hdl/variable_partition_allocator_top_assert.svh =====
// assertion helpers, clocked on i_clk and idle during reset
`ifndef VARIABLE_PARTITION_ALLOCATOR_TOP_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define VPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vpa_pkg.sv =====
package vpa_pkg;

    localparam int POOL_UNITS   = 1024;
    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SIZE_W       = 11;
    localparam int ADDR_W       = 10;
    localparam int OWN_W        = 16;
    localparam int STAT_W       = 32;
    localparam int STRAT_W      = 3;

    localparam logic [STRAT_W-1:0] FIT_FIRST = 3'd0;
    localparam logic [STRAT_W-1:0] FIT_NEXT  = 3'd1;
    localparam logic [STRAT_W-1:0] FIT_BEST  = 3'd2;
    localparam logic [STRAT_W-1:0] FIT_WORST = 3'd3;
    localparam logic [STRAT_W-1:0] FIT_QUICK = 3'd4;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [OWN_W-1:0]  owner;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FIND, S_PLAN, S_SHIFT_RD, S_SHIFT_WR,
        S_COMMIT_A, S_COMMIT_B, S_STAT_GO, S_STAT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_INIT, CMD_LOAD, CMD_FIND, CMD_PLAN, CMD_SHIFT_RD,
        CMD_SHIFT_WR, CMD_COMMIT_A, CMD_COMMIT_B, CMD_STAT_GO, CMD_STAT, CMD_RESULT
    } t_cmd_op;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic two_writes;
        logic out_free;
    } t_status;

    function automatic logic is_quick_size(input logic [SIZE_W-1:0] s);
        return (s == SIZE_W'(16)) || (s == SIZE_W'(32)) || (s == SIZE_W'(64)) ||
               (s == SIZE_W'(128)) || (s == SIZE_W'(256));
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

endpackage

// ===== hdl/vpa_if.sv =====
interface vpa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [vpa_pkg::SIZE_W-1:0]   request_size;
    logic [vpa_pkg::OWN_W-1:0]    owner_id;
    modport source (output valid, func, request_size, owner_id, input ready);
    modport sink   (input valid, func, request_size, owner_id, output ready);
endinterface

interface vpa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [vpa_pkg::ADDR_W-1:0]   segment_start;
    logic [vpa_pkg::SIZE_W-1:0]   used_units;
    logic [vpa_pkg::SIZE_W-1:0]   free_units;
    logic [vpa_pkg::SIZE_W-1:0]   fragmentation;
    logic [vpa_pkg::CNT_W-1:0]    free_segment_count;
    logic [vpa_pkg::STAT_W-1:0]   requests_seen;
    logic [vpa_pkg::STAT_W-1:0]   successes_seen;
    logic [vpa_pkg::STAT_W-1:0]   failures_seen;
    logic [vpa_pkg::STAT_W-1:0]   units_requested;
    logic [vpa_pkg::STAT_W-1:0]   units_granted;
    modport source (output valid, granted, segment_start, used_units, free_units,
                    fragmentation, free_segment_count, requests_seen, successes_seen,
                    failures_seen, units_requested, units_granted, input ready);
    modport sink   (input valid, granted, segment_start, used_units, free_units,
                    fragmentation, free_segment_count, requests_seen, successes_seen,
                    failures_seen, units_requested, units_granted, output ready);
endinterface

// ===== hdl/vpa_ctrl.sv =====
module vpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  vpa_pkg::t_status  i_status,
    output vpa_pkg::t_cmd_op  o_cmd,
    output logic              o_in_ready
);
    import vpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:     n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_FIND;
            S_FIND:     if (i_status.scan_done) n_state = S_PLAN;
            S_PLAN:     n_state = S_SHIFT_RD;
            S_SHIFT_RD: n_state = i_status.shift_done ? S_COMMIT_A : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_COMMIT_A: n_state = i_status.two_writes ? S_COMMIT_B : S_STAT_GO;
            S_COMMIT_B: n_state = S_STAT_GO;
            S_STAT_GO:  n_state = S_STAT;
            S_STAT:     if (i_status.scan_done) n_state = S_DONE;
            S_DONE:     if (i_status.out_free) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT:     o_cmd = CMD_INIT;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LOAD;
            end
            S_FIND:     o_cmd = CMD_FIND;
            S_PLAN:     o_cmd = CMD_PLAN;
            S_SHIFT_RD: if (!i_status.shift_done) o_cmd = CMD_SHIFT_RD;
            S_SHIFT_WR: o_cmd = CMD_SHIFT_WR;
            S_COMMIT_A: o_cmd = CMD_COMMIT_A;
            S_COMMIT_B: o_cmd = CMD_COMMIT_B;
            S_STAT_GO:  o_cmd = CMD_STAT_GO;
            S_STAT:     o_cmd = CMD_STAT;
            S_DONE:     if (i_status.out_free) o_cmd = CMD_RESULT;
            default:    o_cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== hdl/vpa_dpath.sv =====
`include "variable_partition_allocator_top_assert.svh"

module vpa_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vpa_pkg::STRAT_W-1:0]   i_cfg_wdata,
    input  logic                          i_func,
    input  logic [vpa_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [vpa_pkg::OWN_W-1:0]     i_owner_id,
    input  vpa_pkg::t_cmd_op              i_cmd,
    output vpa_pkg::t_status              o_status,
    vpa_out_if.source                     o_rsp
);
    import vpa_pkg::*;

    t_entry r_mem [MAX_SEGMENTS];
    t_entry r_q;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;
    t_entry           w_wdata;

    logic [STRAT_W-1:0] r_fit_strategy;
    logic [CNT_W-1:0]   r_total;
    logic [ADDR_W-1:0]  r_cursor;

    logic               r_func;
    logic [SIZE_W-1:0]  r_req;
    logic [OWN_W-1:0]   r_owner;

    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic [SIZE_W-1:0]  r_addr;
    logic               r_past;

    logic               r_pr_found, r_fb_found;
    logic [IDX_W-1:0]   r_pr_idx, r_fb_idx;
    logic [SIZE_W-1:0]  r_pr_size, r_fb_size;
    logic [ADDR_W-1:0]  r_pr_start, r_fb_start;

    logic               r_hit, r_hit_pfree, r_got_next, r_next_free, r_prev_used;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [SIZE_W-1:0]  r_hit_size, r_hit_psize, r_next_size, r_prev_size;
    logic [ADDR_W-1:0]  r_hit_start;

    logic               r_ok, r_two, r_sh_up;
    logic [ADDR_W-1:0]  r_where;
    logic [1:0]         r_sh_dist;
    logic [IDX_W-1:0]   r_sh_src;
    logic [CNT_W-1:0]   r_sh_left;
    logic [IDX_W-1:0]   r_wa_idx, r_wb_idx;
    t_entry             r_wa_data, r_wb_data;

    logic [STAT_W-1:0]  r_req_cnt, r_succ_cnt, r_fail_cnt, r_req_sum, r_grant_sum;
    logic [SIZE_W-1:0]  r_used, r_free, r_largest;
    logic [CNT_W-1:0]   r_nfree;
    logic               r_out_valid;

    // scan step on the entry read last cycle
    logic               w_issue;
    logic               w_fit;
    logic               w_contains;
    logic               w_past;
    logic               w_pr_take;
    logic [SIZE_W:0]    w_end;

    // plan terms
    logic               w_sel_found;
    logic [IDX_W-1:0]   w_sel_idx;
    logic [SIZE_W-1:0]  w_sel_size;
    logic [ADDR_W-1:0]  w_sel_start;
    logic               w_split;
    logic               w_alloc_ok;
    logic               w_nf;
    logic [1:0]         w_rm;
    logic [IDX_W-1:0]   w_p;
    logic [SIZE_W-1:0]  w_merged;
    logic [CNT_W-1:0]   w_rel_left;

    assign w_issue    = r_idx < r_total;
    assign w_fit      = !r_q.used && (r_q.size >= r_req);
    assign w_end      = {1'b0, r_addr} + {1'b0, r_q.size};
    assign w_contains = ({1'b0, r_addr} <= {2'b0, r_cursor}) && ({2'b0, r_cursor} < w_end);
    assign w_past     = r_past | w_contains;

    always_comb begin
        case (r_fit_strategy)
            FIT_FIRST: w_pr_take = w_fit && !r_pr_found;
            FIT_NEXT:  w_pr_take = w_fit && w_past && !r_pr_found;
            FIT_BEST:  w_pr_take = w_fit && (!r_pr_found || (r_q.size < r_pr_size));
            FIT_WORST: w_pr_take = w_fit && (!r_pr_found || (r_q.size > r_pr_size));
            FIT_QUICK: w_pr_take = !r_q.used && (r_q.size == r_req) &&
                                   is_quick_size(r_req) && !r_pr_found;
            default:   w_pr_take = 1'b0;
        endcase
    end

    always_comb begin
        w_sel_found = 1'b0;
        w_sel_idx   = r_fb_idx;
        w_sel_size  = r_fb_size;
        w_sel_start = r_fb_start;
        if (r_pr_found) begin
            w_sel_found = 1'b1;
            w_sel_idx   = r_pr_idx;
            w_sel_size  = r_pr_size;
            w_sel_start = r_pr_start;
        end else if ((r_fit_strategy == FIT_NEXT || r_fit_strategy == FIT_QUICK) &&
                     r_fb_found) begin
            w_sel_found = 1'b1;
        end
    end

    assign w_split    = w_sel_size > r_req;
    assign w_alloc_ok = (r_req != '0) && w_sel_found &&
                        !(w_split && (r_total >= CNT_W'(MAX_SEGMENTS)));
    assign w_nf       = r_got_next && r_next_free;
    assign w_rm       = {1'b0, r_hit_pfree} + {1'b0, w_nf};
    assign w_p        = r_hit_pfree ? r_hit_idx - IDX_W'(1) : r_hit_idx;
    assign w_merged   = r_hit_size + (r_hit_pfree ? r_hit_psize : '0) +
                        (w_nf ? r_next_size : '0);
    assign w_rel_left = r_total - CNT_W'(1) - {1'b0, w_p} - CNT_W'(w_rm);

    // memory ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa_idx;
        w_wdata = r_wa_data;
        w_raddr = r_idx[IDX_W-1:0];
        case (i_cmd)
            CMD_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{used: 1'b0, size: SIZE_W'(POOL_UNITS), owner: '0};
            end
            CMD_SHIFT_RD: w_raddr = r_sh_src;
            CMD_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_sh_up ? r_sh_src + IDX_W'(1) : r_sh_src - IDX_W'(r_sh_dist);
                w_wdata = r_q;
            end
            CMD_COMMIT_A: w_we = r_ok;
            CMD_COMMIT_B: begin
                w_we    = 1'b1;
                w_waddr = r_wb_idx;
                w_wdata = r_wb_data;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_q <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_strategy <= FIT_FIRST;
            r_total        <= CNT_W'(1);
            r_cursor       <= '0;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_req_cnt      <= '0;
            r_succ_cnt     <= '0;
            r_fail_cnt     <= '0;
            r_req_sum      <= '0;
            r_grant_sum    <= '0;
            r_out_valid    <= 1'b0;
            r_ok           <= 1'b0;
            r_two          <= 1'b0;
            r_sh_left      <= '0;
        end else begin
            if (i_cfg_we) r_fit_strategy <= i_cfg_wdata;
            if (i_cmd == CMD_RESULT) r_out_valid <= 1'b1;
            else if (r_out_valid && o_rsp.ready) r_out_valid <= 1'b0;
            case (i_cmd)
                CMD_LOAD: begin
                    r_func     <= i_func;
                    r_req      <= i_request_size;
                    r_owner    <= i_owner_id;
                    r_idx      <= '0;
                    r_pend     <= 1'b0;
                    r_addr     <= '0;
                    r_past     <= 1'b0;
                    r_pr_found <= 1'b0;
                    r_fb_found <= 1'b0;
                    r_hit      <= 1'b0;
                    r_got_next <= 1'b0;
                end
                CMD_FIND, CMD_STAT: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_idx  <= r_idx + CNT_W'(1);
                        r_pidx <= r_idx[IDX_W-1:0];
                    end
                    if (r_pend) begin
                        r_addr <= w_end[SIZE_W-1:0];
                        if (i_cmd == CMD_FIND) begin
                            r_past      <= w_past;
                            r_prev_used <= r_q.used;
                            r_prev_size <= r_q.size;
                            if (w_pr_take) begin
                                r_pr_found <= 1'b1;
                                r_pr_idx   <= r_pidx;
                                r_pr_size  <= r_q.size;
                                r_pr_start <= r_addr[ADDR_W-1:0];
                            end
                            if (w_fit && !r_fb_found) begin
                                r_fb_found <= 1'b1;
                                r_fb_idx   <= r_pidx;
                                r_fb_size  <= r_q.size;
                                r_fb_start <= r_addr[ADDR_W-1:0];
                            end
                            if (!r_hit && r_q.used && (r_q.owner == r_owner)) begin
                                r_hit       <= 1'b1;
                                r_hit_idx   <= r_pidx;
                                r_hit_size  <= r_q.size;
                                r_hit_start <= r_addr[ADDR_W-1:0];
                                r_hit_pfree <= (r_pidx != '0) && !r_prev_used;
                                r_hit_psize <= r_prev_size;
                            end else if (r_hit && !r_got_next) begin
                                r_got_next  <= 1'b1;
                                r_next_free <= !r_q.used;
                                r_next_size <= r_q.size;
                            end
                        end else begin
                            if (r_q.used) begin
                                r_used <= r_used + r_q.size;
                            end else begin
                                r_free  <= r_free + r_q.size;
                                r_nfree <= r_nfree + CNT_W'(1);
                                if (r_q.size > r_largest) r_largest <= r_q.size;
                            end
                        end
                    end
                end
                CMD_PLAN: begin
                    if (r_func == FUNC_ALLOC) begin
                        r_ok      <= w_alloc_ok;
                        r_where   <= w_alloc_ok ? w_sel_start : '0;
                        r_two     <= w_alloc_ok && w_split;
                        r_sh_up   <= 1'b1;
                        r_sh_dist <= 2'd1;
                        r_sh_src  <= r_idx[IDX_W-1:0] - IDX_W'(1);
                        r_sh_left <= (w_alloc_ok && w_split) ?
                                     r_total - CNT_W'(1) - {1'b0, w_sel_idx} : '0;
                        r_wa_idx  <= w_sel_idx;
                        r_wa_data <= '{used: 1'b1, size: (w_split ? r_req : w_sel_size),
                                       owner: r_owner};
                        r_wb_idx  <= w_sel_idx + IDX_W'(1);
                        r_wb_data <= '{used: 1'b0, size: w_sel_size - r_req, owner: '0};
                        if (w_alloc_ok && w_split) r_total <= r_total + CNT_W'(1);
                        if (w_alloc_ok && r_fit_strategy == FIT_NEXT) r_cursor <= w_sel_start;
                        r_req_cnt <= sat_add(r_req_cnt, STAT_W'(1));
                        r_req_sum <= sat_add(r_req_sum, STAT_W'(r_req));
                        if (w_alloc_ok) begin
                            r_succ_cnt  <= sat_add(r_succ_cnt, STAT_W'(1));
                            r_grant_sum <= sat_add(r_grant_sum, STAT_W'(r_req));
                        end else begin
                            r_fail_cnt  <= sat_add(r_fail_cnt, STAT_W'(1));
                        end
                    end else begin
                        r_ok      <= r_hit;
                        r_where   <= r_hit ? r_hit_start : '0;
                        r_two     <= 1'b0;
                        r_sh_up   <= 1'b0;
                        r_sh_dist <= w_rm;
                        r_sh_src  <= w_p + IDX_W'(1) + IDX_W'(w_rm);
                        r_sh_left <= (r_hit && w_rm != 2'd0) ? w_rel_left : '0;
                        r_wa_idx  <= w_p;
                        r_wa_data <= '{used: 1'b0, size: w_merged, owner: '0};
                        if (r_hit) r_total <= r_total - CNT_W'(w_rm);
                    end
                end
                CMD_SHIFT_WR: begin
                    r_sh_src  <= r_sh_up ? r_sh_src - IDX_W'(1) : r_sh_src + IDX_W'(1);
                    r_sh_left <= r_sh_left - CNT_W'(1);
                end
                CMD_STAT_GO: begin
                    r_idx     <= '0;
                    r_pend    <= 1'b0;
                    r_addr    <= '0;
                    r_used    <= '0;
                    r_free    <= '0;
                    r_largest <= '0;
                    r_nfree   <= '0;
                end
                default: r_pend <= r_pend;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_RESULT) begin
            o_rsp.granted            <= r_ok;
            o_rsp.segment_start      <= r_where;
            o_rsp.used_units         <= r_used;
            o_rsp.free_units         <= r_free;
            o_rsp.fragmentation      <= r_free - r_largest;
            o_rsp.free_segment_count <= r_nfree;
            o_rsp.requests_seen      <= r_req_cnt;
            o_rsp.successes_seen     <= r_succ_cnt;
            o_rsp.failures_seen      <= r_fail_cnt;
            o_rsp.units_requested    <= r_req_sum;
            o_rsp.units_granted      <= r_grant_sum;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_status    = '{scan_done:  !w_issue && !r_pend,
                           shift_done: r_sh_left == '0,
                           two_writes: r_two,
                           out_free:   !r_out_valid || o_rsp.ready};

    `VPA_ASSERT_IMPL(a_total_range, 1'b1, (r_total != '0) && (r_total <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
    `VPA_ASSERT_IMPL(a_pool_tiled, i_cmd == CMD_RESULT, ({1'b0, r_used} + {1'b0, r_free}) == (SIZE_W + 1)'(POOL_UNITS), "segments do not cover the pool")
    `VPA_ASSERT_IMPL(a_shift_in_table, i_cmd == CMD_SHIFT_WR, {1'b0, w_waddr} < r_total, "shift writes past the table end")
    `VPA_ASSERT_NEXT(a_init_one, i_cmd == CMD_INIT, r_total == CNT_W'(1), "table not single segment after init")

endmodule

// ===== hdl/variable_partition_allocator_top.sv =====
// Variable-partition allocator over a 1024-unit pool with a 64-entry segment table. One request
// (allocate or release) is taken at a time; it is worked off in one scan over the table to find
// the segment, a read and a write per moved entry of a split or a merge, and a second scan for
// the totals, all through a segment memory with one read and one write port. Right after reset
// the whole-pool segment is loaded before the first request is taken. The user must write the
// fit strategy register only while the block is idle; the block itself does not enforce this.
// Codes 5 to 7 make every allocate fail.
module variable_partition_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vpa_pkg::STRAT_W-1:0]   i_cfg_wdata,
    vpa_in_if.sink                        i_req,
    vpa_out_if.source                     o_rsp
);
    import vpa_pkg::*;

    t_cmd_op w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_req.ready = w_in_ready;

    vpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    vpa_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_req.func),
        .i_request_size (i_req.request_size),
        .i_owner_id     (i_req.owner_id),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_rsp          (o_rsp)
    );

endmodule

// ===== tb/sv/tb_variable_partition_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_variable_partition_allocator_top;
    import vpa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] segment_start;
        logic [SIZE_W-1:0] used_units;
        logic [SIZE_W-1:0] free_units;
        logic [SIZE_W-1:0] fragmentation;
        logic [CNT_W-1:0]  free_segment_count;
        logic [STAT_W-1:0] requests_seen;
        logic [STAT_W-1:0] successes_seen;
        logic [STAT_W-1:0] failures_seen;
        logic [STAT_W-1:0] units_requested;
        logic [STAT_W-1:0] units_granted;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [STRAT_W-1:0] i_cfg_wdata;

    vpa_in_if  req_if ();
    vpa_out_if rsp_if ();

    variable_partition_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // shadow allocator state
    int unsigned tbl_start [MAX_SEGMENTS];
    int unsigned tbl_size  [MAX_SEGMENTS];
    bit          tbl_used  [MAX_SEGMENTS];
    int unsigned tbl_owner [MAX_SEGMENTS];
    int unsigned tbl_count;
    int unsigned cursor_addr;
    logic [STRAT_W-1:0] strategy;
    logic [STAT_W-1:0] cnt_req, cnt_ok, cnt_fail, sum_req, sum_grant;

    t_outcome pending_outcomes[$];
    int  error_count;
    bit  sink_stalls;
    bit  src_gaps;
    bit  hold_sink;
    int  quiet_cycles = 0;
    bit  done_flag;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [STAT_W-1:0] add_sat(logic [STAT_W-1:0] a, int unsigned b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + (STAT_W+1)'(b);
        return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

    function automatic bit seg_fits(int unsigned i, int unsigned req);
        return !tbl_used[i] && tbl_size[i] >= req;
    endfunction

    function automatic int first_free(int unsigned req);
        for (int unsigned i = 0; i < tbl_count; i++)
            if (seg_fits(i, req)) return i;
        return -1;
    endfunction

    function automatic int choose_segment(int unsigned req);
        int pick;
        int unsigned k;
        pick = -1;
        k = 0;
        case (strategy)
            FIT_FIRST: pick = first_free(req);
            FIT_NEXT: begin
                for (int unsigned i = 0; i < tbl_count; i++)
                    if (tbl_start[i] <= cursor_addr && cursor_addr - tbl_start[i] < tbl_size[i])
                        k = i;
                for (int unsigned i = k; i < tbl_count && pick < 0; i++)
                    if (seg_fits(i, req)) pick = i;
                for (int unsigned i = 0; i < k && pick < 0; i++)
                    if (seg_fits(i, req)) pick = i;
            end
            FIT_BEST, FIT_WORST: begin
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (!seg_fits(i, req)) continue;
                    if (pick < 0 || (strategy == FIT_WORST ? tbl_size[i] > tbl_size[pick]
                                                           : tbl_size[i] < tbl_size[pick]))
                        pick = i;
                end
            end
            FIT_QUICK: begin
                if (req inside {16, 32, 64, 128, 256})
                    for (int unsigned i = 0; i < tbl_count && pick < 0; i++)
                        if (!tbl_used[i] && tbl_size[i] == req) pick = i;
                if (pick < 0) pick = first_free(req);
            end
            default: pick = -1;
        endcase
        return pick;
    endfunction

    function automatic void drop_entry(int unsigned j);
        for (int unsigned k = j; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_used[k]  = tbl_used[k+1];
            tbl_owner[k] = tbl_owner[k+1];
        end
        tbl_count--;
    endfunction

    function automatic t_outcome predict_allocator(logic func, int unsigned req,
                                                   int unsigned owner);
        t_outcome o;
        bit ok;
        int pick;
        int unsigned i, where, used, freeu, largest, nfree;
        ok = 0;
        where = 0;
        if (func == FUNC_ALLOC) begin
            pick = (req == 0) ? -1 : choose_segment(req);
            if (pick >= 0) begin
                i = pick;
                ok = 1;
                if (tbl_size[i] > req) begin
                    if (tbl_count >= MAX_SEGMENTS) ok = 0;
                    else begin
                        for (int unsigned k = tbl_count; k > i + 1; k--) begin
                            tbl_start[k] = tbl_start[k-1];
                            tbl_size[k]  = tbl_size[k-1];
                            tbl_used[k]  = tbl_used[k-1];
                            tbl_owner[k] = tbl_owner[k-1];
                        end
                        tbl_start[i+1] = tbl_start[i] + req;
                        tbl_size[i+1]  = tbl_size[i] - req;
                        tbl_used[i+1]  = 0;
                        tbl_owner[i+1] = 0;
                        tbl_size[i] = req;
                        tbl_count++;
                    end
                end
                if (ok) begin
                    tbl_used[i] = 1;
                    tbl_owner[i] = owner;
                    if (strategy == FIT_NEXT) cursor_addr = tbl_start[i];
                    where = tbl_start[i];
                end
            end
            cnt_req = add_sat(cnt_req, 1);
            sum_req = add_sat(sum_req, req);
            if (ok) begin
                cnt_ok = add_sat(cnt_ok, 1);
                sum_grant = add_sat(sum_grant, req);
            end else cnt_fail = add_sat(cnt_fail, 1);
        end else begin
            i = tbl_count;
            for (int unsigned k = 0; k < tbl_count; k++)
                if (tbl_used[k] && tbl_owner[k] == owner) begin
                    i = k;
                    break;
                end
            if (i < tbl_count) begin
                ok = 1;
                where = tbl_start[i];
                tbl_used[i] = 0;
                tbl_owner[i] = 0;
                if (i + 1 < tbl_count && !tbl_used[i+1]) begin
                    tbl_size[i] += tbl_size[i+1];
                    drop_entry(i + 1);
                end
                if (i > 0 && !tbl_used[i-1]) begin
                    tbl_size[i-1] += tbl_size[i];
                    drop_entry(i);
                end
            end
        end
        used = 0; freeu = 0; largest = 0; nfree = 0;
        for (int unsigned k = 0; k < tbl_count; k++) begin
            if (tbl_used[k]) used += tbl_size[k];
            else begin
                freeu += tbl_size[k];
                nfree++;
                if (tbl_size[k] > largest) largest = tbl_size[k];
            end
        end
        o.granted = ok;
        o.segment_start = ok ? ADDR_W'(where) : '0;
        o.used_units = SIZE_W'(used);
        o.free_units = SIZE_W'(freeu);
        o.fragmentation = SIZE_W'(freeu - largest);
        o.free_segment_count = CNT_W'(nfree);
        o.requests_seen = cnt_req;
        o.successes_seen = cnt_ok;
        o.failures_seen = cnt_fail;
        o.units_requested = sum_req;
        o.units_granted = sum_grant;
        return o;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            tbl_start[i] = 0; tbl_size[i] = 0; tbl_used[i] = 0; tbl_owner[i] = 0;
        end
        tbl_size[0] = POOL_UNITS;
        tbl_count = 1;
        cursor_addr = 0;
        strategy = FIT_FIRST;
        cnt_req = '0; cnt_ok = '0; cnt_fail = '0; sum_req = '0; sum_grant = '0;
    endfunction

    task automatic send_request(logic func, int unsigned req, int unsigned owner);
        t_outcome o;
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= func;
        req_if.request_size <= SIZE_W'(req);
        req_if.owner_id <= OWN_W'(owner);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        o = predict_allocator(func, req, owner);
        pending_outcomes.push_back(o);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        // block is not ready again until the result of a request is out, so this costs no rate
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_strategy(logic [STRAT_W-1:0] s);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= s;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        strategy = s;
    endtask

    // release every owner in the given range so the pool comes back whole
    task automatic release_owners(int unsigned lo, int unsigned hi);
        for (int unsigned o = lo; o <= hi; o++) send_request(FUNC_RELEASE, 0, o);
    endtask

    task automatic test_directed_edges();
        set_strategy(FIT_FIRST);
        send_request(FUNC_ALLOC, 0, 16'hFFFF);
        send_request(FUNC_ALLOC, 1025, 1);
        send_request(FUNC_ALLOC, 2047, 1);
        send_request(FUNC_RELEASE, 0, 7);
        send_request(FUNC_ALLOC, 1, 16'hFFFF);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_RELEASE, 2047, 16'hFFFF);
        send_request(FUNC_RELEASE, 0, 0);
        send_request(FUNC_ALLOC, 1024, 16'h5555);
        send_request(FUNC_ALLOC, 1, 2);
        send_request(FUNC_RELEASE, 0, 16'h5555);
        set_strategy(3'd5);
        send_request(FUNC_ALLOC, 8, 3);
        set_strategy(3'd7);
        send_request(FUNC_ALLOC, 8, 3);
    endtask

    // one-unit grants until the table is full, then a split must fail
    task automatic test_table_full();
        set_strategy(FIT_FIRST);
        for (int unsigned k = 0; k < MAX_SEGMENTS; k++) send_request(FUNC_ALLOC, 1, 100 + k);
        send_request(FUNC_ALLOC, 4, 999);
        send_request(FUNC_ALLOC, 1024 - 63, 998);
        release_owners(100, 100 + MAX_SEGMENTS);
        release_owners(998, 999);
    endtask

    task automatic test_strategies();
        for (int s = FIT_NEXT; s <= FIT_QUICK; s++) begin
            set_strategy(STRAT_W'(s));
            send_request(FUNC_ALLOC, 64, 1);
            send_request(FUNC_ALLOC, 16, 2);
            send_request(FUNC_ALLOC, 32, 3);
            send_request(FUNC_ALLOC, 16, 4);
            send_request(FUNC_RELEASE, 0, 1);
            send_request(FUNC_RELEASE, 0, 3);
            send_request(FUNC_ALLOC, 16, 5);
            send_request(FUNC_ALLOC, 20, 6);
            release_owners(1, 6);
        end
    endtask

    task automatic random_phase(int n, int unsigned owners);
        int unsigned sz;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: sz = 1 << $urandom_range(4, 8);
                1: sz = $urandom_range(0, 2047);
                2, 3: sz = $urandom_range(1, 16);
                default: sz = $urandom_range(1, 120);
            endcase
            if ($urandom_range(0, 9) < 4)
                send_request(FUNC_RELEASE, $urandom_range(0, 2047), $urandom_range(0, owners));
            else if ($urandom_range(0, 49) == 0)
                send_request(FUNC_ALLOC, sz, $urandom_range(0, 65535));
            else
                send_request(FUNC_ALLOC, sz, $urandom_range(0, owners));
        end
    endtask

    task automatic test_random_mix();
        for (int r = 0; r < 10; r++) begin
            set_strategy(STRAT_W'(r % 5));
            random_phase(100, 30);
        end
    endtask

    task automatic test_backpressure();
        set_strategy(FIT_BEST);
        fork
            begin
                hold_sink = 1'b1;
                repeat (2000) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            random_phase(10, 8);
        join
        wait_drained();
    endtask

    task automatic test_no_idle();
        sink_stalls = 1'b0;
        src_gaps = 1'b0;
        set_strategy(FIT_WORST);
        random_phase(60, 20);
        set_strategy(FIT_QUICK);
        random_phase(50, 20);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.granted, rsp_if.segment_start, rsp_if.used_units,
                    rsp_if.free_units, rsp_if.fragmentation, rsp_if.free_segment_count,
                    rsp_if.requests_seen, rsp_if.successes_seen, rsp_if.failures_seen,
                    rsp_if.units_requested, rsp_if.units_granted};
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    error_count++;
                end
            end
        end
    end

    // result ready with random stall bursts
    initial begin
        int burst;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) rsp_if.ready <= 1'b0;
            else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7);
                rsp_if.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || hold_sink
            || done_flag || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        done_flag = 1'b0;
        hold_sink = 1'b0;
        sink_stalls = 1'b1;
        src_gaps = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_ALLOC;
        req_if.request_size = '0;
        req_if.owner_id = '0;
        reset_shadow();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_edges();
        test_table_full();
        test_strategies();
        test_random_mix();
        test_backpressure();
        test_no_idle();
        wait_drained();
        done_flag = 1'b1;
        if (error_count == 0 && pending_outcomes.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vpa_pkg.sv
hdl/vpa_if.sv
hdl/vpa_ctrl.sv
hdl/vpa_dpath.sv
hdl/variable_partition_allocator_top.sv
tb/sv/tb_variable_partition_allocator_top.sv
